// ----- rtl/cdt_pkg.sv -----
// Package for the capability derivation table: payload structs, row layout,
// memory request bundle, operation and status codes, default table sizes.
// No dependencies.
package cdt_pkg;

    localparam int DEF_PROCESS_COUNT     = 8;
    localparam int DEF_SLOTS_PER_PROCESS = 32;
    localparam int MAX_ROWS              = 256;

    localparam logic [2:0] OP_READ   = 3'd0;
    localparam logic [2:0] OP_MOVE   = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_INSERT = 3'd3;
    localparam logic [2:0] OP_UPDATE = 3'd4;
    localparam logic [2:0] OP_SEED   = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_OCCUPIED = 2'd2;
    localparam logic [1:0] ST_NULL_UPD = 2'd3;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  first_index;
        logic [7:0]  second_index;
        logic [63:0] cap_word;
    } cdt_in_t;

    typedef struct packed {
        logic [63:0] stored_word;
        logic [7:0]  slot_depth;
        logic [7:0]  next_slot;
        logic        slot_is_null;
        logic [1:0]  status;
    } cdt_out_t;

    typedef struct packed {
        logic [63:0] word;
        logic [7:0]  depth;
        logic [7:0]  link_prev;
        logic [7:0]  link_next;
    } row_t;

    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] raddr;
        row_t       wdata;
    } mem_req_t;

endpackage

// ----- rtl/cdt_row_mem.sv -----
// Slot row memory: one synchronous read port, one write port, a valid bit
// per row (unwritten rows read as zero) and write-to-read forwarding.
// Depends on cdt_pkg.
module cdt_row_mem #(
    parameter int DEPTH = cdt_pkg::MAX_ROWS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cdt_pkg::mem_req_t req,
    output cdt_pkg::row_t     row
);
    import cdt_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    row_t              mem_array [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    row_t              rdata_reg;
    row_t              fwd_data_reg;
    logic              rvalid_reg;
    logic              fwd_hit_reg;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;

    assign waddr = req.waddr[ADDR_W-1:0];
    assign raddr = req.raddr[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_array[waddr] <= req.wdata;
        end
        rdata_reg    <= mem_array[raddr];
        fwd_data_reg <= req.wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rvalid_reg  <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg  <= valid_reg[raddr];
            fwd_hit_reg <= req.we && (waddr == raddr);
        end
    end

    assign row = fwd_hit_reg ? fwd_data_reg : (rvalid_reg ? rdata_reg : '0);

    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        req.we |=> valid_reg[$past(waddr)])
        else $error("row written but its valid bit is clear");

    a_forward_takes_write: assert property (@(posedge clk) disable iff (!rst_n)
        (req.we && waddr == raddr) |=> row == $past(req.wdata))
        else $error("read of a row written in the same cycle missed the new data");

endmodule

// ----- rtl/cdt_seq.sv -----
// Operation sequencer: checks slots and walks the link updates as a chain of
// read-modify-write steps on the row memory, one row per cycle.
// Depends on cdt_pkg.
module cdt_seq #(
    parameter int PROCESS_COUNT     = cdt_pkg::DEF_PROCESS_COUNT,
    parameter int SLOTS_PER_PROCESS = cdt_pkg::DEF_SLOTS_PER_PROCESS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cdt_pkg::cdt_in_t  in_data,
    input  logic [8:0]        ring_length,
    output cdt_pkg::mem_req_t mem_req,
    input  cdt_pkg::row_t     row,
    output logic              res_valid,
    input  logic              res_ready,
    output cdt_pkg::cdt_out_t res
);
    import cdt_pkg::*;

    localparam int TABLE_SLOTS = PROCESS_COUNT * SLOTS_PER_PROCESS;
    localparam int RING_CAP    = (TABLE_SLOTS < MAX_ROWS) ? TABLE_SLOTS : MAX_ROWS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHKA = 3'd1;
    localparam logic [2:0] S_CHKB = 3'd2;
    localparam logic [2:0] S_L1   = 3'd3;
    localparam logic [2:0] S_L2   = 3'd4;
    localparam logic [2:0] S_L3   = 3'd5;
    localparam logic [2:0] S_RES  = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  op_reg, op_next;
    logic [7:0]  a_reg, a_next;
    logic [7:0]  b_reg, b_next;
    logic [63:0] w_reg, w_next;
    logic [7:0]  p_reg, p_next;
    logic [7:0]  n_reg, n_next;
    logic [7:0]  d_reg, d_next;
    cdt_out_t    res_reg, res_next;

    logic        a_in_table;
    logic        b_in_table;
    logic        a_null;
    logic [8:0]  ring_eff;
    logic [7:0]  seed_prev;
    logic [7:0]  seed_next;
    logic [7:0]  depth_inc;
    row_t        mod_row;

    assign a_in_table = {24'd0, a_reg} < 32'(TABLE_SLOTS);
    assign b_in_table = {24'd0, b_reg} < 32'(TABLE_SLOTS);
    assign a_null     = !a_in_table || (row.word == 64'd0);

    always_comb
    begin
        if (ring_length == 9'd0)
        begin
            ring_eff = 9'd1;
        end
        else if (ring_length > 9'(RING_CAP))
        begin
            ring_eff = 9'(RING_CAP);
        end
        else
        begin
            ring_eff = ring_length;
        end
    end

    assign seed_prev = (b_reg == 8'd0) ? 8'(ring_eff - 9'd1) : b_reg - 8'd1;
    assign seed_next = ({1'b0, b_reg} == ring_eff - 9'd1) ? 8'd0 : b_reg + 8'd1;
    assign depth_inc = (d_reg == 8'hFF) ? d_reg : d_reg + 8'd1;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        w_next     = w_reg;
        p_next     = p_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        res_next   = res_reg;
        mod_row    = row;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        mem_req    = '0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                mem_req.raddr = (in_data.operation == OP_SEED) ? in_data.second_index
                                                               : in_data.first_index;
                if (in_valid)
                begin
                    op_next    = in_data.operation;
                    a_next     = in_data.first_index;
                    b_next     = in_data.second_index;
                    w_next     = in_data.cap_word;
                    res_next   = '0;
                    state_next = S_CHKA;
                end
            end
            S_CHKA:
            begin
                state_next = S_RES;
                case (op_reg)
                    OP_READ:
                    begin
                        if (a_in_table)
                        begin
                            res_next.stored_word = row.word;
                            res_next.slot_depth  = row.depth;
                            res_next.next_slot   = row.link_next;
                        end
                        res_next.slot_is_null = a_null;
                    end
                    OP_UPDATE:
                    begin
                        if (a_null)
                        begin
                            res_next.status = ST_EMPTY;
                        end
                        else if (w_reg == 64'd0)
                        begin
                            res_next.status = ST_NULL_UPD;
                        end
                        else
                        begin
                            mod_row.word  = w_reg;
                            mem_req.we    = 1'b1;
                            mem_req.waddr = a_reg;
                            mem_req.wdata = mod_row;
                        end
                    end
                    OP_SEED:
                    begin
                        if ({1'b0, b_reg} < ring_eff)
                        begin
                            mod_row.word      = w_reg;
                            mod_row.link_prev = seed_prev;
                            mod_row.link_next = seed_next;
                            mem_req.we        = 1'b1;
                            mem_req.waddr     = b_reg;
                            mem_req.wdata     = mod_row;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (a_null)
                        begin
                            res_next.status = ST_EMPTY;
                        end
                        else
                        begin
                            p_next        = row.link_prev;
                            n_next        = row.link_next;
                            mem_req.raddr = row.link_prev;
                            state_next    = S_L1;
                        end
                    end
                    OP_MOVE, OP_INSERT:
                    begin
                        if (a_null)
                        begin
                            res_next.status = ST_EMPTY;
                        end
                        else
                        begin
                            p_next        = row.link_prev;
                            n_next        = row.link_next;
                            d_next        = row.depth;
                            mem_req.raddr = b_reg;
                            state_next    = S_CHKB;
                        end
                    end
                    default:
                    begin
                        state_next = S_RES;
                    end
                endcase
            end
            S_CHKB:
            begin
                if (!b_in_table || row.word != 64'd0)
                begin
                    res_next.status = ST_OCCUPIED;
                    state_next      = S_RES;
                end
                else if (op_reg == OP_MOVE)
                begin
                    mem_req.we              = 1'b1;
                    mem_req.waddr           = b_reg;
                    mem_req.wdata.word      = w_reg;
                    mem_req.wdata.depth     = d_reg;
                    mem_req.wdata.link_prev = p_reg;
                    mem_req.wdata.link_next = n_reg;
                    mem_req.raddr           = p_reg;
                    state_next              = S_L1;
                end
                else
                begin
                    mem_req.raddr = a_reg;
                    state_next    = S_L1;
                end
            end
            S_L1:
            begin
                mod_row.link_next = (op_reg == OP_DELETE) ? n_reg : b_reg;
                mem_req.we        = 1'b1;
                mem_req.waddr     = (op_reg == OP_INSERT) ? a_reg : p_reg;
                mem_req.wdata     = mod_row;
                mem_req.raddr     = n_reg;
                state_next        = S_L2;
            end
            S_L2:
            begin
                mod_row.link_prev = (op_reg == OP_DELETE) ? p_reg : b_reg;
                mem_req.we        = 1'b1;
                mem_req.waddr     = n_reg;
                mem_req.wdata     = mod_row;
                mem_req.raddr     = a_reg;
                state_next        = S_L3;
            end
            S_L3:
            begin
                mem_req.we = 1'b1;
                if (op_reg == OP_INSERT)
                begin
                    mem_req.waddr           = b_reg;
                    mem_req.wdata.word      = w_reg;
                    mem_req.wdata.depth     = depth_inc;
                    mem_req.wdata.link_prev = a_reg;
                    mem_req.wdata.link_next = n_reg;
                end
                else
                begin
                    mod_row.word  = 64'd0;
                    mem_req.waddr = a_reg;
                    mem_req.wdata = mod_row;
                end
                state_next = S_RES;
            end
            S_RES:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        w_reg   <= w_next;
        p_reg   <= p_next;
        n_reg   <= n_next;
        d_reg   <= d_next;
        res_reg <= res_next;
    end

    assign res = res_reg;

    a_no_write_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_RES) |-> !mem_req.we)
        else $error("table written outside an operation");

    a_accept_starts_check: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == S_CHKA)
        else $error("accepted transaction did not start with the slot check");

    a_link_chain_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_L1 |=> state_reg == S_L2 ##1 state_reg == S_L3 ##1 state_reg == S_RES)
        else $error("link update chain broken");

endmodule

// ----- rtl/capability_derivation_table_top.sv -----
// Top level of the capability derivation table: ring length register,
// result register, sequencer and row memory.
// Depends on cdt_pkg, cdt_row_mem and cdt_seq.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------
//  in       | in_valid / in_ready   | in_data   (cdt_in_t)
//  out      | out_valid / out_ready | out_data  (cdt_out_t)
//  cfg      | cfg_valid / cfg_ready | cfg_data  (ring length, 9 bits)
//
// One transaction at a time; each step reads and writes at most one row. Read,
// update, seed and unused codes end after the slot check; delete adds steps L1,
// L2 and L3; move and insert also check the second slot first. Reset clears the
// per-row valid bits at once, so no clearing pass is needed. A stalled output
// holds its result in the output register while the next transaction is
// accepted; a second result waits in the sequencer until the register frees.
module capability_derivation_table_top #(
    parameter int PROCESS_COUNT     = cdt_pkg::DEF_PROCESS_COUNT,
    parameter int SLOTS_PER_PROCESS = cdt_pkg::DEF_SLOTS_PER_PROCESS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cdt_pkg::cdt_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output cdt_pkg::cdt_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [8:0]        cfg_data
);
    import cdt_pkg::*;

    localparam int TABLE_SLOTS = PROCESS_COUNT * SLOTS_PER_PROCESS;
    localparam int ROWS        = (TABLE_SLOTS < MAX_ROWS) ? TABLE_SLOTS : MAX_ROWS;

    logic [8:0] ring_length_reg;
    logic       out_valid_reg;
    cdt_out_t   out_data_reg;
    mem_req_t   mem_req;
    row_t       row;
    logic       res_valid;
    logic       res_ready;
    cdt_out_t   res;

    assign cfg_ready = 1'b1;
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_length_reg <= 9'd1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                ring_length_reg <= cfg_data;
            end
            if (res_valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    cdt_seq #(
        .PROCESS_COUNT     (PROCESS_COUNT),
        .SLOTS_PER_PROCESS (SLOTS_PER_PROCESS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .ring_length (ring_length_reg),
        .mem_req     (mem_req),
        .row         (row),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    cdt_row_mem #(
        .DEPTH (ROWS)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .row   (row)
    );

endmodule

// ----- tb/capability_derivation_table_top_test.sv -----
// Self-checking testbench for capability_derivation_table_top: directed table, depth climb
// and random phases over several ring lengths, checked against a slot table predictor.
// Depends on cdt_pkg and capability_derivation_table_top.
module capability_derivation_table_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cdt_pkg::*;

    localparam int TABLE_SLOTS  = DEF_PROCESS_COUNT * DEF_SLOTS_PER_PROCESS;
    localparam int RING_CAP     = TABLE_SLOTS < MAX_ROWS ? TABLE_SLOTS : MAX_ROWS;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_OPS   = 60;
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    typedef struct {
        cdt_in_t  item;
        bit       known;
        cdt_out_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    cdt_in_t     in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    cdt_out_t    out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [8:0]  cfg_data = '0;

    logic [63:0] word_of  [0:MAX_ROWS-1];
    logic [7:0]  prev_of  [0:MAX_ROWS-1];
    logic [7:0]  next_of  [0:MAX_ROWS-1];
    logic [7:0]  depth_of [0:MAX_ROWS-1];
    logic [8:0]  ring_len = 9'd1;

    cdt_out_t    expected_results[$];
    int          mismatches = 0;
    bit          idle_on = 1'b1;

    capability_derivation_table_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < MAX_ROWS; i++)
        begin
            word_of[i]  = '0;
            prev_of[i]  = '0;
            next_of[i]  = '0;
            depth_of[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic bit is_null(input int i);
        return i >= TABLE_SLOTS || word_of[i] == 64'd0;
    endfunction

    function automatic int ring_effective();
        int l;
        l = ring_len;
        if (l < 1)
            l = 1;
        if (l > RING_CAP)
            l = RING_CAP;
        return l;
    endfunction

    function automatic cdt_out_t apply_operation(input cdt_in_t t);
        cdt_out_t   r;
        int         a;
        int         b;
        int         l;
        logic [7:0] p;
        logic [7:0] n;
        logic [7:0] d;
        r = '0;
        a = t.first_index;
        b = t.second_index;
        case (t.operation)
            OP_READ:
            begin
                if (a < TABLE_SLOTS)
                begin
                    r.stored_word = word_of[a];
                    r.slot_depth  = depth_of[a];
                    r.next_slot   = next_of[a];
                end
                r.slot_is_null = is_null(a);
            end
            OP_MOVE:
            begin
                if (is_null(a))
                    r.status = ST_EMPTY;
                else if (b >= TABLE_SLOTS || !is_null(b))
                    r.status = ST_OCCUPIED;
                else
                begin
                    d = depth_of[a];
                    p = prev_of[a];
                    n = next_of[a];
                    prev_of[b]  = p;
                    next_of[b]  = n;
                    word_of[b]  = t.cap_word;
                    depth_of[b] = d;
                    next_of[p]  = b[7:0];
                    prev_of[n]  = b[7:0];
                    word_of[a]  = '0;
                end
            end
            OP_DELETE:
            begin
                if (is_null(a))
                    r.status = ST_EMPTY;
                else
                begin
                    p = prev_of[a];
                    n = next_of[a];
                    next_of[p] = n;
                    prev_of[n] = p;
                    word_of[a] = '0;
                end
            end
            OP_INSERT:
            begin
                if (is_null(a))
                    r.status = ST_EMPTY;
                else if (b >= TABLE_SLOTS || !is_null(b))
                    r.status = ST_OCCUPIED;
                else
                begin
                    n = next_of[a];
                    next_of[a]  = b[7:0];
                    prev_of[n]  = b[7:0];
                    depth_of[b] = depth_of[a] == 8'd255 ? 8'd255 : depth_of[a] + 8'd1;
                    prev_of[b]  = a[7:0];
                    next_of[b]  = n;
                    word_of[b]  = t.cap_word;
                end
            end
            OP_UPDATE:
            begin
                if (is_null(a))
                    r.status = ST_EMPTY;
                else if (t.cap_word == 64'd0)
                    r.status = ST_NULL_UPD;
                else
                    word_of[a] = t.cap_word;
            end
            OP_SEED:
            begin
                l = ring_effective();
                if (b < l)
                begin
                    prev_of[b] = b == 0 ? 8'(l - 1) : 8'(b - 1);
                    next_of[b] = b == l - 1 ? 8'd0 : 8'(b + 1);
                    word_of[b] = t.cap_word;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic cdt_in_t make_item(input logic [2:0] op, input int a, input int b,
                                          input logic [63:0] w);
        cdt_in_t t;
        t.operation    = op;
        t.first_index  = a[7:0];
        t.second_index = b[7:0];
        t.cap_word     = w;
        return t;
    endfunction

    function automatic cdt_out_t make_result(input logic [63:0] w, input int d, input int n,
                                             input bit nul, input logic [1:0] st);
        cdt_out_t r;
        r.stored_word  = w;
        r.slot_depth   = d[7:0];
        r.next_slot    = n[7:0];
        r.slot_is_null = nul;
        r.status       = st;
        return r;
    endfunction

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] live_word();
        logic [63:0] w;
        do
            w = random_word();
        while (w == 64'd0);
        return w;
    endfunction

    function automatic int pick_slot(input bit occupied);
        int i;
        repeat (8)
        begin
            i = $urandom_range(MAX_ROWS - 1);
            if (!is_null(i) == occupied)
                return i;
        end
        return $urandom_range(MAX_ROWS - 1);
    endfunction

    function automatic cdt_in_t random_item(input int l);
        logic [63:0] w;
        int          r;
        int          a;
        int          b;
        logic [2:0]  op;
        r = $urandom_range(99);
        case ($urandom_range(19))
            0:       w = '0;
            1:       w = '1;
            default: w = random_word();
        endcase
        a = $urandom_range(MAX_ROWS - 1);
        b = $urandom_range(MAX_ROWS - 1);
        if (r < 18)
        begin
            op = OP_READ;
            if ($urandom_range(1))
                a = pick_slot(1'b1);
        end
        else if (r < 33 || (r >= 45 && r < 63))
        begin
            op = r < 33 ? OP_MOVE : OP_INSERT;
            if ($urandom_range(99) < 85)
                a = pick_slot(1'b1);
            if ($urandom_range(99) < 85)
                b = pick_slot(1'b0);
        end
        else if (r < 45 || (r >= 63 && r < 75))
        begin
            op = r < 45 ? OP_DELETE : OP_UPDATE;
            if ($urandom_range(99) < 80)
                a = pick_slot(1'b1);
        end
        else if (r < 85)
        begin
            op = OP_SEED;
            if ($urandom_range(99) < 80)
                b = $urandom_range(l);
        end
        else if (r < 90)
            op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
        else
            op = 3'($urandom_range(7));
        return make_item(op, a, b, w);
    endfunction

    task automatic submit(input cdt_in_t t, input bit known, input cdt_out_t want);
        cdt_out_t predicted;
        if (idle_on && $urandom_range(99) < 34)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 34);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = apply_operation(t);
        expected_results.push_back(known ? want : predicted);
    endtask

    task automatic issue(input cdt_in_t t);
        submit(t, 1'b0, '0);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_ring(input logic [8:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        ring_len = v;
    endtask

    task automatic clear_table();
        for (int i = 0; i < TABLE_SLOTS; i++)
            if (!is_null(i))
                issue(make_item(OP_DELETE, i, 0, random_word()));
    endtask

    // Output side: check each transaction, then choose readiness for the next edge.
    always @(posedge clk)
    begin
        cdt_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: word %h depth %0d next %0d null %0d status %0d",
                             out_data.stored_word, out_data.slot_depth, out_data.next_slot,
                             out_data.slot_is_null, out_data.status);
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_data.stored_word !== want.stored_word ||
                    out_data.slot_depth !== want.slot_depth ||
                    out_data.next_slot !== want.next_slot ||
                    out_data.slot_is_null !== want.slot_is_null ||
                    out_data.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("expected: word %h depth %0d next %0d null %0d status %0d",
                                 want.stored_word, want.slot_depth, want.next_slot,
                                 want.slot_is_null, want.status);
                        $display("actual:   word %h depth %0d next %0d null %0d status %0d",
                                 out_data.stored_word, out_data.slot_depth, out_data.next_slot,
                                 out_data.slot_is_null, out_data.status);
                    end
                end
            end
        end
        out_ready <= idle_on ? ($urandom_range(99) >= 34) : 1'b1;
    end

    initial
    begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall = 0;
            else
                stall++;
        end
        $display("capability_derivation_table_top: mismatch");
        $finish;
    end

    initial
    begin
        stim_row_t   rows[$];
        logic [8:0]  lengths[5];
        logic [63:0] ones;
        int          l;
        ones = '1;

        rows.push_back('{make_item(OP_READ, 0, 0, 0), 1, make_result(0, 0, 0, 1, ST_OK)});
        rows.push_back('{make_item(OP_READ, 255, 255, ones), 1, make_result(0, 0, 0, 1, ST_OK)});
        rows.push_back('{make_item(OP_MOVE, 0, 1, ones), 1, make_result(0, 0, 0, 0, ST_EMPTY)});
        rows.push_back('{make_item(OP_DELETE, 7, 0, 0), 1, make_result(0, 0, 0, 0, ST_EMPTY)});
        rows.push_back('{make_item(OP_INSERT, 0, 3, 9), 1, make_result(0, 0, 0, 0, ST_EMPTY)});
        rows.push_back('{make_item(OP_UPDATE, 0, 0, 5), 1, make_result(0, 0, 0, 0, ST_EMPTY)});
        rows.push_back('{make_item(OP_SPARE_A, 255, 255, ones), 1, make_result(0, 0, 0, 0, ST_OK)});
        rows.push_back('{make_item(OP_SPARE_B, 0, 0, ones), 1, make_result(0, 0, 0, 0, ST_OK)});
        rows.push_back('{make_item(OP_SEED, 0, 1, ones), 1, make_result(0, 0, 0, 0, ST_OK)});
        rows.push_back('{make_item(OP_READ, 1, 0, 0), 1, make_result(0, 0, 0, 1, ST_OK)});
        rows.push_back('{make_item(OP_SEED, 0, 0, ones), 1, make_result(0, 0, 0, 0, ST_OK)});
        rows.push_back('{make_item(OP_READ, 0, 0, 0), 1, make_result(ones, 0, 0, 0, ST_OK)});
        rows.push_back('{make_item(OP_UPDATE, 0, 0, 0), 1, make_result(0, 0, 0, 0, ST_NULL_UPD)});
        rows.push_back('{make_item(OP_UPDATE, 0, 0, 64'h8000_0000_0000_0001), 0, '0});
        rows.push_back('{make_item(OP_INSERT, 0, 255, 1), 0, '0});
        rows.push_back('{make_item(OP_INSERT, 0, 255, 2), 1, make_result(0, 0, 0, 0, ST_OCCUPIED)});
        rows.push_back('{make_item(OP_MOVE, 255, 0, 3), 1, make_result(0, 0, 0, 0, ST_OCCUPIED)});
        rows.push_back('{make_item(OP_READ, 255, 0, 0), 0, '0});
        rows.push_back('{make_item(OP_MOVE, 255, 128, 64'h5555_5555_5555_5555), 0, '0});
        rows.push_back('{make_item(OP_READ, 128, 0, 0), 0, '0});
        rows.push_back('{make_item(OP_READ, 0, 0, 0), 0, '0});
        rows.push_back('{make_item(OP_DELETE, 128, 0, 0), 0, '0});
        rows.push_back('{make_item(OP_DELETE, 128, 0, 0), 1, make_result(0, 0, 0, 0, ST_EMPTY)});
        rows.push_back('{make_item(OP_INSERT, 0, 0, 4), 1, make_result(0, 0, 0, 0, ST_OCCUPIED)});
        rows.push_back('{make_item(OP_MOVE, 0, 200, 0), 0, '0});
        rows.push_back('{make_item(OP_READ, 200, 0, 0), 0, '0});
        rows.push_back('{make_item(OP_READ, 0, 0, 0), 0, '0});

        do
            @(posedge clk);
        while (!rst_n);

        foreach (rows[i])
            submit(rows[i].item, rows[i].known, rows[i].want);

        // Chain inserts across the whole table to drive the depth to saturation.
        settle();
        write_ring(9'd0);
        clear_table();
        issue(make_item(OP_SEED, 0, 0, live_word()));
        for (int i = 1; i < TABLE_SLOTS; i++)
            issue(make_item(OP_INSERT, i - 1, i, live_word()));
        issue(make_item(OP_INSERT, 0, 5, live_word()));
        issue(make_item(OP_DELETE, 1, 0, 0));
        issue(make_item(OP_INSERT, TABLE_SLOTS - 1, 1, live_word()));
        issue(make_item(OP_READ, 1, 0, 0));
        issue(make_item(OP_READ, TABLE_SLOTS - 1, 0, 0));

        lengths = '{9'd511, 9'd2, 9'($urandom_range(3, 40)),
                    9'($urandom_range(1, 64)), 9'd1};
        foreach (lengths[ph])
        begin
            settle();
            idle_on = ph != 0;
            write_ring(lengths[ph]);
            l = ring_effective();
            for (int i = 0; i < l; i++)
                issue(make_item(OP_SEED, $urandom_range(255), i, live_word()));
            for (int k = 0; k < RANDOM_OPS; k++)
                issue(random_item(l));
        end

        settle();
        mismatches += expected_results.size();
        if (mismatches == 0)
            $display("capability_derivation_table_top: match");
        else
            $display("capability_derivation_table_top: mismatch");
        $finish;
    end

endmodule
